// ----- rtl/lspl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspl_pkg
// Shared constants, codes and types of the looping sample player.
// ----------------------------------------------------------------------------
package lspl_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int FRAC_BITS      = 16;
    localparam int MAX_FRAMES     = 65536;
    localparam int ADDR_BITS      = $clog2(MAX_FRAMES);
    localparam int FRAME_BITS     = ADDR_BITS + 1;
    localparam int POS_BITS       = FRAME_BITS + FRAC_BITS;
    localparam int RATE_BITS      = 27;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = RATE_BITS;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int IN_DATA_BITS   = ADDR_BITS + SAMPLE_BITS;
    localparam int OUT_DATA_BITS  = SAMPLE_BITS;
    localparam int CMD_BITS       = 2;
    localparam int OUT_USER_BITS  = 2;

    localparam logic [RATE_BITS-1:0]  ONE_RATE     = RATE_BITS'(1) << FRAC_BITS;
    localparam logic [RATE_BITS-1:0]  MAX_RATE     = RATE_BITS'(1024) << FRAC_BITS;
    localparam logic [FRAME_BITS-1:0] MAX_FRAMES_F = FRAME_BITS'(MAX_FRAMES);

    typedef enum logic [CMD_BITS-1:0] {
        CMD_WRITE  = 2'd0,
        CMD_RENDER = 2'd1,
        CMD_START  = 2'd2
    } cmd_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_LOOP_ENABLE = 3'd0,
        REG_LOOP_START  = 3'd1,
        REG_LOOP_END    = 3'd2,
        REG_END_FRAME   = 3'd3,
        REG_BUFFER_LEN  = 3'd4,
        REG_RATE        = 3'd5
    } reg_index_t;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [FRAC_BITS-1:0]   frac_t;
    typedef logic [POS_BITS-1:0]    pos_t;
    typedef logic [FRAME_BITS-1:0]  frame_t;
    typedef logic [ADDR_BITS-1:0]   addr_t;
    typedef logic [RATE_BITS-1:0]   rate_t;

    // Values derived from the configuration registers, held stable between writes
    typedef struct packed {
        logic   loop_en;
        frame_t blen;
        pos_t   endf_pos;
        pos_t   vend_pos;
        pos_t   vdelta_pos;
        rate_t  rate;
        logic   rate_guard;
    } cfg_t;

    // One render request waiting for interpolation
    typedef struct packed {
        sample_t s1;
        sample_t s2;
        frac_t   frac;
        logic    finished;
        logic    guarded;
    } entry_t;

endpackage

// ----- rtl/lspl_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspl_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module lspl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_a <= mem_reg[rd_addr_a];
        rd_data_b <= mem_reg[rd_addr_b];
    end

endmodule

// ----- rtl/lspl_config.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspl_config
// Configuration registers and the registered values derived from them.
// ----------------------------------------------------------------------------
module lspl_config (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lspl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lspl_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output lspl_pkg::cfg_t                      derived,
    output logic                                stale
);
    import lspl_pkg::*;

    logic                  loop_en_reg;
    logic [ADDR_BITS-1:0]  loop_start_reg;
    frame_t                loop_end_reg;
    frame_t                end_frame_reg;
    frame_t                buffer_len_reg;
    rate_t                 rate_reg;
    logic                  stale_reg;
    cfg_t                  derived_reg;
    cfg_t                  derived_next;

    frame_t                blen_c;
    frame_t                endf_c;
    frame_t                vend_c;
    logic                  loop_act;
    logic [FRAME_BITS:0]   vdelta_c;
    logic                  delta_nonpos;
    logic                  cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_en_reg    <= 1'b0;
            loop_start_reg <= '0;
            loop_end_reg   <= '0;
            end_frame_reg  <= MAX_FRAMES_F;
            buffer_len_reg <= '0;
            rate_reg       <= ONE_RATE;
            stale_reg      <= 1'b1;
        end
        else
        begin
            stale_reg <= cfg_write;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_LOOP_ENABLE: loop_en_reg    <= cfg_data[0];
                    REG_LOOP_START:  loop_start_reg <= cfg_data[ADDR_BITS-1:0];
                    REG_LOOP_END:    loop_end_reg   <= cfg_data[FRAME_BITS-1:0];
                    REG_END_FRAME:   end_frame_reg  <= cfg_data[FRAME_BITS-1:0];
                    REG_BUFFER_LEN:  buffer_len_reg <= cfg_data[FRAME_BITS-1:0];
                    REG_RATE:        rate_reg       <= cfg_data[RATE_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        blen_c   = (buffer_len_reg > MAX_FRAMES_F) ? MAX_FRAMES_F : buffer_len_reg;
        endf_c   = (end_frame_reg > blen_c) ? blen_c : end_frame_reg;
        loop_act = loop_en_reg && (loop_end_reg > {1'b0, loop_start_reg});
        vend_c   = (loop_act && (loop_end_reg < endf_c)) ? loop_end_reg : endf_c;
        vdelta_c = loop_act ? ({1'b0, vend_c} - {2'b00, loop_start_reg}) : {1'b0, endf_c};
        delta_nonpos = vdelta_c[FRAME_BITS] || (vdelta_c == '0);

        derived_next.loop_en    = loop_en_reg;
        derived_next.blen       = blen_c;
        derived_next.endf_pos   = {endf_c, FRAC_BITS'(0)};
        derived_next.vend_pos   = {vend_c, FRAC_BITS'(0)};
        derived_next.vdelta_pos = {vdelta_c[FRAME_BITS-1:0], FRAC_BITS'(0)};
        if (rate_reg == '0)
            derived_next.rate = ONE_RATE;
        else if (rate_reg > MAX_RATE)
            derived_next.rate = MAX_RATE;
        else
            derived_next.rate = rate_reg;
        derived_next.rate_guard = delta_nonpos ||
                                  (POS_BITS'(derived_next.rate) >= derived_next.vdelta_pos);
    end

    // Derived values register after a write; stale holds until they settle
    always_ff @(posedge clk)
    begin
        derived_reg <= derived_next;
    end

    assign derived = derived_reg;
    assign stale   = stale_reg;

endmodule

// ----- rtl/lspl_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspl_front
// Command front end: sample writes, start, position update and memory reads.
// ----------------------------------------------------------------------------
module lspl_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [lspl_pkg::CMD_BITS-1:0]       in_cmd,
    input  lspl_pkg::addr_t                     in_addr,
    input  lspl_pkg::sample_t                   in_sample,
    input  lspl_pkg::cfg_t                      cfg,
    input  logic                                stale,
    input  logic [lspl_pkg::QUEUE_PTR_BITS:0]   q_level,
    output logic                                push_valid,
    output lspl_pkg::entry_t                    push_entry
);
    import lspl_pkg::*;

    localparam int LVL_BITS = QUEUE_PTR_BITS + 2;
    localparam int T_BITS   = POS_BITS + 2;

    pos_t                  pos_reg;
    pos_t                  pos_next;
    logic                  done_reg;
    logic                  done_next;
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  s1_zero_reg;
    logic                  s1_zero_next;
    frac_t                 s1_frac_reg;
    frac_t                 s1_frac_next;
    logic                  s1_finished_reg;
    logic                  s1_finished_next;
    logic                  s1_guarded_reg;
    logic                  s1_guarded_next;

    logic                  accept;
    logic                  ram_we;
    sample_t               rd_a;
    sample_t               rd_b;
    logic [LVL_BITS-1:0]   level_sum;

    pos_t                  pos0;
    addr_t                 idx;
    frame_t                idx_p1;
    frame_t                idx2;
    logic                  wrap_idx;
    logic [T_BITS-1:0]     t_pos;
    logic                  idx_bad;
    logic [POS_BITS:0]     pos_sum;
    logic [POS_BITS:0]     pos_adv;
    logic                  pass_end;

    assign level_sum = LVL_BITS'(q_level) + LVL_BITS'(s1_valid_reg);
    assign in_ready  = !stale && (level_sum < LVL_BITS'(QUEUE_DEPTH));
    assign accept    = in_valid && in_ready;

    // Read position and interpolation indexes
    always_comb
    begin
        pos0     = (pos_reg >= cfg.endf_pos) ? '0 : pos_reg;
        idx      = pos0[FRAC_BITS +: ADDR_BITS];
        idx_p1   = {1'b0, idx} + FRAME_BITS'(1);
        wrap_idx = idx_p1 >= cfg.blen;
        t_pos    = T_BITS'(pos0) + (T_BITS'(1) << FRAC_BITS) - T_BITS'(cfg.vdelta_pos);
        if (!wrap_idx)
            idx2 = idx_p1;
        else if (cfg.loop_en)
            idx2 = t_pos[FRAC_BITS +: FRAME_BITS];
        else
            idx2 = {1'b0, idx};
        idx_bad  = ({1'b0, idx} >= cfg.blen) ||
                   (wrap_idx && cfg.loop_en && t_pos[T_BITS-1]) ||
                   (idx2 >= cfg.blen);
        pos_sum  = {1'b0, pos0} + (POS_BITS+1)'(cfg.rate);
        pass_end = pos_sum >= {1'b0, cfg.vend_pos};
        pos_adv  = pass_end ? (pos_sum - {1'b0, cfg.vdelta_pos}) : pos_sum;
    end

    always_comb
    begin
        pos_next         = pos_reg;
        done_next        = done_reg;
        ram_we           = 1'b0;
        s1_valid_next    = 1'b0;
        s1_zero_next     = s1_zero_reg;
        s1_frac_next     = s1_frac_reg;
        s1_finished_next = s1_finished_reg;
        s1_guarded_next  = s1_guarded_reg;
        if (accept)
        begin
            unique case (in_cmd)
                CMD_WRITE:
                begin
                    ram_we = 1'b1;
                end
                CMD_START:
                begin
                    pos_next  = POS_BITS'({in_addr, FRAC_BITS'(0)});
                    done_next = 1'b0;
                end
                CMD_RENDER:
                begin
                    s1_valid_next    = 1'b1;
                    s1_frac_next     = pos0[FRAC_BITS-1:0];
                    s1_zero_next     = 1'b1;
                    s1_guarded_next  = 1'b0;
                    s1_finished_next = done_reg;
                    if (!done_reg)
                    begin
                        if (cfg.rate_guard || idx_bad)
                        begin
                            // silent; position keeps the reset to zero
                            pos_next        = pos0;
                            s1_guarded_next = 1'b1;
                        end
                        else
                        begin
                            pos_next     = pos_adv[POS_BITS-1:0];
                            s1_zero_next = 1'b0;
                            if (pass_end && !cfg.loop_en)
                            begin
                                done_next        = 1'b1;
                                s1_finished_next = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            done_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            done_reg     <= done_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_zero_reg     <= s1_zero_next;
        s1_frac_reg     <= s1_frac_next;
        s1_finished_reg <= s1_finished_next;
        s1_guarded_reg  <= s1_guarded_next;
    end

    lspl_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_FRAMES)
    ) u_sample_ram (
        .clk       (clk),
        .wr_en     (ram_we),
        .wr_addr   (in_addr),
        .wr_data   (in_sample),
        .rd_addr_a (idx),
        .rd_data_a (rd_a),
        .rd_addr_b (idx2[ADDR_BITS-1:0]),
        .rd_data_b (rd_b)
    );

    // Silent renders push zero samples, which interpolate to zero
    assign push_valid          = s1_valid_reg;
    assign push_entry.s1       = s1_zero_reg ? '0 : rd_a;
    assign push_entry.s2       = s1_zero_reg ? '0 : rd_b;
    assign push_entry.frac     = s1_frac_reg;
    assign push_entry.finished = s1_finished_reg;
    assign push_entry.guarded  = s1_guarded_reg;

endmodule

// ----- rtl/lspl_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspl_queue
// Small register queue between the front end and the interpolator.
// ----------------------------------------------------------------------------
module lspl_queue (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push_valid,
    input  lspl_pkg::entry_t                  push_entry,
    input  logic                              pop,
    output logic                              head_valid,
    output lspl_pkg::entry_t                  head_entry,
    output logic [lspl_pkg::QUEUE_PTR_BITS:0] level
);
    import lspl_pkg::*;

    entry_t                    slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_next;
    logic [QUEUE_PTR_BITS:0]   level_reg;
    logic [QUEUE_PTR_BITS:0]   level_next;

    // front end never pushes into a full queue
    always_comb
    begin
        wr_ptr_next = push_valid ? wr_ptr_reg + QUEUE_PTR_BITS'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_PTR_BITS'(1) : rd_ptr_reg;
        level_next  = level_reg + (QUEUE_PTR_BITS+1)'(push_valid)
                      - (QUEUE_PTR_BITS+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head_valid = level_reg != '0;
    assign head_entry = slot_reg[rd_ptr_reg];
    assign level      = level_reg;

endmodule

// ----- rtl/lspl_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspl_back
// Linear interpolator and output register.
// ----------------------------------------------------------------------------
module lspl_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     head_valid,
    input  lspl_pkg::entry_t         head_entry,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_ready,
    output lspl_pkg::sample_t        out_sample,
    output logic                     out_finished,
    output logic                     out_guarded
);
    import lspl_pkg::*;

    localparam int PROD_BITS = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int ACC_BITS  = PROD_BITS + 1;
    localparam logic [ACC_BITS-1:0] HALF = ACC_BITS'(1) << (FRAC_BITS - 1);

    logic                        out_valid_reg;
    logic                        out_valid_next;
    sample_t                     sample_reg;
    logic                        finished_reg;
    logic                        guarded_reg;

    sample_t                     s1;
    sample_t                     s2;
    logic signed [SAMPLE_BITS:0] diff;
    logic signed [PROD_BITS-1:0] prod;
    logic signed [ACC_BITS-1:0]  acc;

    assign pop = head_valid && (!out_valid_reg || out_ready);

    // out = floor((s1 * 2^F + (s2 - s1) * frac + 2^(F-1)) / 2^F)
    always_comb
    begin
        s1   = head_entry.s1;
        s2   = head_entry.s2;
        diff = $signed({s2[SAMPLE_BITS-1], s2}) - $signed({s1[SAMPLE_BITS-1], s1});
        prod = diff * $signed({1'b0, head_entry.frac});
        acc  = $signed({{(ACC_BITS-SAMPLE_BITS-FRAC_BITS){s1[SAMPLE_BITS-1]}},
                        s1, FRAC_BITS'(0)})
               + $signed({prod[PROD_BITS-1], prod})
               + $signed(HALF);
        out_valid_next = pop || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            sample_reg   <= acc[FRAC_BITS +: SAMPLE_BITS];
            finished_reg <= head_entry.finished;
            guarded_reg  <= head_entry.guarded;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_sample   = sample_reg;
    assign out_finished = finished_reg;
    assign out_guarded  = guarded_reg;

endmodule

// ----- rtl/looping_sample_player_lerp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// looping_sample_player_lerp
// Mono sample-playback voice with linear interpolation and loop wrap.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries requests: tuser = command (write sample, render, start),
//   tdata = {sample_value, address}. Writes fill the 64K-entry sample RAM,
//   start sets the read position to a frame and clears the finished flag,
//   render yields one result on m_axis.
//   m_axis carries results: tdata = sample_out, tuser = {guarded, finished}.
//   cfg_* writes one of six registers (loop enable, loop start, loop end,
//   end frame, buffer length, rate); cfg_ready is always high.
// Throughput: one request per cycle while no config write settles and the
//   queue has room, set by the front-end position update and two RAM ports.
// Path: a render passes the RAM read, the queue and the interpolator output
//   register before it shows on m_axis.
// A config write blocks s_axis for the following cycle while derived loop
//   values settle. Reset clears position, finished flag, queue and output;
//   s_axis is held off after reset until derived values register. The sample
//   RAM is not cleared. When m_axis stalls, up to four renders wait in the
//   queue and one in the output register; s_axis drops ready once that space is used.
// ----------------------------------------------------------------------------
module looping_sample_player_lerp (
    input  logic                                clk,
    input  logic                                rst_n,
    // request channel
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [lspl_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,  // [15:0] address, [31:16] sample_value
    input  logic [lspl_pkg::CMD_BITS-1:0]       s_axis_tuser,  // [1:0] command
    // result channel
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [lspl_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,  // [15:0] sample_out
    output logic [lspl_pkg::OUT_USER_BITS-1:0]  m_axis_tuser,  // [0] finished, [1] guarded
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lspl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [lspl_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import lspl_pkg::*;

    cfg_t                    derived;
    logic                    stale;
    logic                    push_valid;
    entry_t                  push_entry;
    logic                    pop;
    logic                    head_valid;
    entry_t                  head_entry;
    logic [QUEUE_PTR_BITS:0] q_level;
    sample_t                 out_sample;
    logic                    out_finished;
    logic                    out_guarded;

    lspl_config u_config (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .derived   (derived),
        .stale     (stale)
    );

    // Front: decode, position step, RAM reads
    lspl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_cmd     (s_axis_tuser),
        .in_addr    (s_axis_tdata[ADDR_BITS-1:0]),
        .in_sample  (s_axis_tdata[ADDR_BITS +: SAMPLE_BITS]),
        .cfg        (derived),
        .stale      (stale),
        .q_level    (q_level),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    lspl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .level      (q_level)
    );

    // Back: interpolation and output register
    lspl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .pop          (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_sample   (out_sample),
        .out_finished (out_finished),
        .out_guarded  (out_guarded)
    );

    assign m_axis_tdata = out_sample;
    assign m_axis_tuser = {out_guarded, out_finished};

endmodule

// ----- rtl/lspl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lspl_checker
// Port-level checks of the sample player, bound to the top level.
// ----------------------------------------------------------------------------
module lspl_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tready,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [lspl_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    input  logic [lspl_pkg::OUT_USER_BITS-1:0]  m_axis_tuser,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready
);
    import lspl_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // requests are held off the cycle after a config write
    a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !s_axis_tready)
        else $error("request accepted while config settles");

    // a guarded result is silent
    a_guard_silent: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0)
        else $error("guarded result not silent");

    // a finished voice is never guarded
    a_fin_guard: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("finished and guarded both set");

endmodule

bind looping_sample_player_lerp lspl_checker u_lspl_checker (.*);
